FILE: rtl/mbh_pkg.sv
// shared types, constants and helpers for the link boot handshake master
`timescale 1ns / 1ps
package mbh_pkg;

  // default limits handed to the top level
  localparam int DEF_MAX_ATTEMPTS       = 16;
  localparam int DEF_PROBES_PER_ATTEMPT = 16;

  // command words sent to the clients
  localparam logic [15:0] CMD_PROBE     = 16'h6200;
  localparam logic [15:0] CMD_ANNOUNCE  = 16'h6100;
  localparam logic [15:0] CMD_POLL      = 16'h6300;
  localparam logic [15:0] CMD_HANDSHAKE = 16'h6400;

  // client replies
  localparam logic [15:0] RSP_ACK       = 16'h7200;
  localparam logic [15:0] RSP_ACK_MASK  = 16'hFFF0;
  localparam logic [15:0] RSP_POLL      = 16'h7300;
  localparam logic [15:0] RSP_POLL_MASK = 16'hFF00;

  // header length in halfwords
  localparam logic [6:0] HEADER_HALVES = 7'h60;

  // palette register reset value and handshake seed
  localparam logic [7:0] PALETTE_RESET = 8'h81;
  localparam logic [7:0] HS_SEED       = 8'h11;
  localparam logic [7:0] HS_FILL       = 8'hFF;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_DISCOVER  = 4'd1,
    PH_ANNOUNCE  = 4'd2,
    PH_HEADER    = 4'd3,
    PH_CONFIRM1  = 4'd4,
    PH_CONFIRM2  = 4'd5,
    PH_POLL      = 4'd6,
    PH_HANDSHAKE = 4'd7,
    PH_DONE      = 4'd8,
    PH_NOCLIENT  = 4'd9,
    PH_BADREPLY  = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_DONE     = 2'd1,
    ST_NOCLIENT = 2'd2,
    ST_BADREPLY = 2'd3
  } status_t;

  // handshake progress kept between beats
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  mask;
    logic [4:0]  attempts;
    logic [4:0]  probes;
    logic [6:0]  hdr_cnt;
    logic [7:0]  answer;
  } mbh_state_t;

  localparam mbh_state_t STATE_RESET = '{
    phase: PH_IDLE, mask: 4'd0, attempts: 5'd0, probes: 5'd0, hdr_cnt: 7'd0, answer: 8'd0
  };

  // one result beat
  typedef struct packed {
    logic [15:0] send_word;
    logic        send_valid;
    status_t     status;
    logic [3:0]  clients_found;
    logic [6:0]  header_position;
    logic [7:0]  handshake_value;
    logic [7:0]  client_answer;
  } mbh_result_t;

  // handshake byte, sum taken modulo 256
  function automatic logic [7:0] hs_byte(input logic [7:0] answer);
    hs_byte = answer + HS_SEED + HS_FILL + HS_FILL;
  endfunction

endpackage

FILE: rtl/multiboot_handshake_master_top.sv
// top level of the link boot handshake master
//
// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready  tdata reply_word, header_word; tuser mode
// out_     out  out_tvalid/out_tready tdata send_word..client_answer; tuser send_valid
// cfg_     in   cfg_valid/cfg_ready  cfg_data palette_byte
//
// one beat in, one beat out; a result appears in the cycle after its input beat
// a beat is taken every cycle while the result register is empty or being drained
// the only loop is the state register through the step logic
// synchronous active-low reset clears state, palette goes to 0x81
// out_tready low holds the result and stalls the input side; cfg is always ready
`timescale 1ns / 1ps
module multiboot_handshake_master_top
  import mbh_pkg::*;
#(
  parameter int MAX_ATTEMPTS       = DEF_MAX_ATTEMPTS,
  parameter int PROBES_PER_ATTEMPT = DEF_PROBES_PER_ATTEMPT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // reply_word[31:0], header_word[47:32]
  input  logic [0:0]  in_tuser,   // mode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // send_word[15:0], status[17:16], clients_found[21:18],
                                  // header_position[28:22], handshake_value[36:29],
                                  // client_answer[44:37], zero fill[47:45]
  output logic [0:0]  out_tuser,  // send_valid[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // palette_byte
);

  mbh_state_t  state_r, state_nxt;
  mbh_result_t res_r, res_nxt;
  logic        out_valid_r;
  logic [7:0]  palette_r;
  logic        in_beat;

  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  mbh_step #(
    .MAX_ATTEMPTS       (MAX_ATTEMPTS),
    .PROBES_PER_ATTEMPT (PROBES_PER_ATTEMPT)
  ) u_step (
    .cur         (state_r),
    .mode        (in_tuser[0]),
    .reply_word  (in_tdata[31:0]),
    .header_word (in_tdata[47:32]),
    .palette     (palette_r),
    .nxt         (state_nxt),
    .res         (res_nxt)
  );

  // handshake state advances on each input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (in_beat) begin
      state_r <= state_nxt;
    end
  end

  // palette register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_r <= PALETTE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      palette_r <= cfg_data;
    end
  end

  // result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_beat) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.send_valid;
  assign out_tdata  = {3'd0, res_r.client_answer, res_r.handshake_value,
                       res_r.header_position, res_r.clients_found, res_r.status,
                       res_r.send_word};

  // a word to send only comes while the handshake is still running
  a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.send_valid |-> res_r.status == ST_BUSY)
    else $error("send beat with final status");

  // nothing to send means a zero word
  a_idle_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.send_valid |-> res_r.send_word == 16'd0)
    else $error("non-zero word without send");

  // a start beat yields the first probe and restarts discovery
  a_start_probe: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && !in_tuser[0] |=> out_valid_r && res_r.send_word == CMD_PROBE &&
      state_r.phase == PH_DISCOVER && state_r.mask == 4'd0)
    else $error("start beat did not restart discovery");

  // header position never runs past the header length
  a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.header_position <= HEADER_HALVES)
    else $error("header position out of range");

endmodule

FILE: rtl/mbh_step.sv
// next-state and result logic for one handshake beat
`timescale 1ns / 1ps
module mbh_step
  import mbh_pkg::*;
#(
  parameter int MAX_ATTEMPTS       = DEF_MAX_ATTEMPTS,
  parameter int PROBES_PER_ATTEMPT = DEF_PROBES_PER_ATTEMPT
) (
  input  mbh_state_t  cur,
  input  logic        mode,
  input  logic [31:0] reply_word,
  input  logic [15:0] header_word,
  input  logic [7:0]  palette,
  output mbh_state_t  nxt,
  output mbh_result_t res
);

  logic [15:0] word;
  logic        send;
  logic [4:0]  att_inc;
  logic [7:0]  hdr_tag;
  logic [31:0] ack_exp;
  logic [31:0] hdr_exp;
  logic [31:0] mask_exp;
  logic        poll_hit;

  // expected replies for the current client mask
  assign att_inc  = cur.attempts + 5'd1;
  assign hdr_tag  = {1'b0, HEADER_HALVES - (cur.hdr_cnt - 7'd1)};
  assign ack_exp  = {16'd0, RSP_ACK | {12'd0, cur.mask}};
  assign hdr_exp  = {16'd0, hdr_tag, 4'd0, cur.mask};
  assign mask_exp = {28'd0, cur.mask};
  assign poll_hit = (reply_word[15:0] & RSP_POLL_MASK) == RSP_POLL;

  // phase sequencing
  always_comb begin
    nxt  = cur;
    word = 16'd0;
    send = 1'b0;
    if (!mode) begin
      nxt       = STATE_RESET;
      nxt.phase = PH_DISCOVER;
      nxt.probes = 5'd1;
      word      = CMD_PROBE;
      send      = 1'b1;
    end else begin
      unique case (cur.phase)
        PH_DISCOVER: begin
          if ((reply_word[15:0] & RSP_ACK_MASK) == RSP_ACK) begin
            nxt.mask = cur.mask | reply_word[3:0];
          end
          if (cur.probes < 5'(PROBES_PER_ATTEMPT)) begin
            nxt.probes = cur.probes + 5'd1;
            word       = CMD_PROBE;
            send       = 1'b1;
          end else if (nxt.mask != 4'd0) begin
            nxt.phase = PH_ANNOUNCE;
            word      = CMD_ANNOUNCE | {12'd0, nxt.mask};
            send      = 1'b1;
          end else begin
            nxt.attempts = att_inc;
            if (att_inc >= 5'(MAX_ATTEMPTS)) begin
              nxt.phase = PH_NOCLIENT;
            end else begin
              nxt.probes = 5'd1;
              word       = CMD_PROBE;
              send       = 1'b1;
            end
          end
        end
        PH_ANNOUNCE: begin
          if (reply_word != ack_exp) begin
            nxt.phase = PH_BADREPLY;
          end else begin
            nxt.phase   = PH_HEADER;
            nxt.hdr_cnt = 7'd1;
            word        = header_word;
            send        = 1'b1;
          end
        end
        PH_HEADER: begin
          if (cur.hdr_cnt == 7'd0 || cur.hdr_cnt > HEADER_HALVES || reply_word != hdr_exp) begin
            nxt.phase = PH_BADREPLY;
          end else if (cur.hdr_cnt < HEADER_HALVES) begin
            nxt.hdr_cnt = cur.hdr_cnt + 7'd1;
            word        = header_word;
            send        = 1'b1;
          end else begin
            nxt.phase = PH_CONFIRM1;
            word      = CMD_PROBE;
            send      = 1'b1;
          end
        end
        PH_CONFIRM1: begin
          if (reply_word != mask_exp) begin
            nxt.phase = PH_BADREPLY;
          end else begin
            nxt.phase = PH_CONFIRM2;
            word      = CMD_PROBE | {12'd0, cur.mask};
            send      = 1'b1;
          end
        end
        PH_CONFIRM2: begin
          if (reply_word != ack_exp) begin
            nxt.phase = PH_BADREPLY;
          end else begin
            nxt.phase = PH_POLL;
            word      = CMD_POLL | {8'd0, palette};
            send      = 1'b1;
          end
        end
        PH_POLL: begin
          send = 1'b1;
          if (poll_hit) begin
            nxt.answer = reply_word[7:0];
            nxt.phase  = PH_HANDSHAKE;
            word       = CMD_HANDSHAKE | {8'd0, hs_byte(reply_word[7:0])};
          end else begin
            word = CMD_POLL | {8'd0, palette};
          end
        end
        PH_HANDSHAKE: begin
          nxt.phase = poll_hit ? PH_DONE : PH_BADREPLY;
        end
        PH_DONE, PH_NOCLIENT, PH_BADREPLY: begin
          nxt.phase = cur.phase;
        end
        default: begin
          nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

  // result fields from the updated state
  always_comb begin
    res.send_word       = send ? word : 16'd0;
    res.send_valid      = send;
    res.clients_found   = nxt.mask;
    res.header_position = nxt.hdr_cnt;
    res.client_answer   = nxt.answer;
    res.handshake_value = (nxt.phase == PH_HANDSHAKE || nxt.phase == PH_DONE) ?
                          hs_byte(nxt.answer) : 8'd0;
    case (nxt.phase)
      PH_DONE:     res.status = ST_DONE;
      PH_NOCLIENT: res.status = ST_NOCLIENT;
      PH_BADREPLY: res.status = ST_BADREPLY;
      default:     res.status = ST_BUSY;
    endcase
  end

endmodule
